@@ rtl/core/msc_pkg.sv @@
// Shared widths, register indexes and payload types of the maximum-subarray finder.
`default_nettype none

package msc_pkg;

    // Field widths.
    localparam int PIX_W     = 13;
    localparam int IDX_W     = 8;
    localparam int RUN_W     = 21;
    localparam int BEST_W    = 20;
    localparam int SUM_OUT_W = 19;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 8;

    // Largest value the best-sum output can show.
    localparam logic [BEST_W-1:0] SUM_OUT_MAX = BEST_W'((1 << SUM_OUT_W) - 1);

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WINDOW_START = 1'b0,
        REG_WINDOW_END   = 1'b1
    } cfg_reg_t;

    typedef logic signed [PIX_W-1:0] pix_val_t;
    typedef logic signed [RUN_W-1:0] run_t;
    typedef logic [IDX_W-1:0]        idx_t;

    // Search window as held in the configuration registers.
    typedef struct packed {
        idx_t start;
        idx_t stop;
    } win_t;

    // One incoming pixel.
    typedef struct packed {
        pix_val_t pixel_value;
        logic     line_end;
    } pix_t;

    // Best run of a finished line, before output formatting.
    typedef struct packed {
        logic [BEST_W-1:0] best_sum;
        idx_t              best_start;
        idx_t              best_end;
    } res_t;

endpackage

`default_nettype wire

@@ rtl/core/msc_if.sv @@
// Channel interfaces: pixel stream, line result and configuration write.
`default_nettype none

interface msc_pix_if import msc_pkg::*; ();
    logic     valid;
    logic     ready;
    pix_val_t pixel_value;
    logic     line_end;

    modport source (output valid, output pixel_value, output line_end, input ready);
    modport sink   (input valid, input pixel_value, input line_end, output ready);
endinterface

interface msc_res_if import msc_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [SUM_OUT_W-1:0] best_sum;
    idx_t                 best_start;
    idx_t                 best_end;
    idx_t                 center;

    modport source (output valid, output best_sum, output best_start, output best_end,
                    output center, input ready);
    modport sink   (input valid, input best_sum, input best_start, input best_end,
                    input center, output ready);
endinterface

interface msc_cfg_if import msc_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/core/msc_cfg_regs.sv @@
// Window configuration registers with their write decoder.
`default_nettype none

module msc_cfg_regs import msc_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    msc_cfg_if.sink   cfg,
    output win_t      win
);

    idx_t start_reg;
    idx_t stop_reg;
    idx_t start_next;
    idx_t stop_next;

    // Writes are always taken.
    assign cfg.ready = 1'b1;

    // Register write decoder.
    always_comb
    begin
        start_next = start_reg;
        stop_next  = stop_reg;
        if (cfg.valid)
        begin
            unique case (cfg_reg_t'(cfg.index))
                REG_WINDOW_START: start_next = IDX_W'(cfg.data);
                REG_WINDOW_END:   stop_next  = IDX_W'(cfg.data);
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= '0;
            stop_reg  <= IDX_W'(127);
        end
        else
        begin
            start_reg <= start_next;
            stop_reg  <= stop_next;
        end
    end

    assign win = '{start: start_reg, stop: stop_reg};

endmodule

`default_nettype wire

@@ rtl/core/msc_kadane.sv @@
// Input register and per-pixel running-sum / best-run update.
`default_nettype none

module msc_kadane import msc_pkg::*;
#(
    parameter int LINE_PIXELS = 128
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire win_t win,
    input  wire logic in_valid,
    output logic      in_ready,
    input  wire pix_t in_pix,
    output logic      res_valid,
    output res_t      res_data,
    input  wire logic res_space
);

    localparam idx_t LINE_LEN = IDX_W'(LINE_PIXELS);

    // Input register.
    logic s1_valid_reg;
    logic s1_valid_next;
    pix_t s1_pix_reg;

    // Line state.
    idx_t              idx_reg,        idx_next;
    run_t              run_sum_reg,    run_sum_next;
    idx_t              run_start_reg,  run_start_next;
    logic [BEST_W-1:0] best_sum_reg,   best_sum_next;
    idx_t              best_start_reg, best_start_next;
    idx_t              best_end_reg,   best_end_next;

    logic in_fire;
    logic s1_fire;

    // A line-closing pixel needs room in the output stage; others never wait.
    assign s1_fire  = s1_valid_reg && (!s1_pix_reg.line_end || res_space);
    assign in_ready = !s1_valid_reg || s1_fire;
    assign in_fire  = in_valid && in_ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_fire)
            s1_valid_next = 1'b1;
        else if (s1_fire)
            s1_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
            s1_pix_reg <= in_pix;
    end

    // Kadane step for the registered pixel.
    always_comb
    begin
        run_t rs;
        run_t rs_sum;
        idx_t rst;
        logic [BEST_W-1:0] bs;
        idx_t bst;
        idx_t be;
        idx_t ix;

        ix  = idx_reg;
        rs  = run_sum_reg;
        rst = run_start_reg;
        bs  = best_sum_reg;
        bst = best_start_reg;
        be  = best_end_reg;
        rs_sum = '0;

        if (ix < LINE_LEN)
        begin
            // Reaching the window start opens an empty run there.
            if (ix == win.start)
            begin
                rs  = '0;
                rst = ix;
                bs  = '0;
                bst = ix;
                be  = ix;
            end
            if ((ix >= win.start) && (ix < win.stop))
            begin
                if (rs[RUN_W-1])
                begin
                    rs  = '0;
                    rst = ix;
                end
                rs_sum = rs + RUN_W'(s1_pix_reg.pixel_value);
                rs     = rs_sum;
                if (!rs_sum[RUN_W-1] && (rs_sum != '0) && (rs_sum[BEST_W-1:0] > bs))
                begin
                    bs  = rs_sum[BEST_W-1:0];
                    bst = rst;
                    be  = ix + 1'b1;
                end
            end
            ix = ix + 1'b1;
        end

        res_data.best_sum   = bs;
        res_data.best_start = bst;
        res_data.best_end   = be;
        res_valid           = s1_fire && s1_pix_reg.line_end;

        // The end of a line restores the cleared line state.
        if (s1_pix_reg.line_end)
        begin
            idx_next        = '0;
            run_sum_next    = '0;
            run_start_next  = win.start;
            best_sum_next   = '0;
            best_start_next = win.start;
            best_end_next   = win.start;
        end
        else
        begin
            idx_next        = ix;
            run_sum_next    = rs;
            run_start_next  = rst;
            best_sum_next   = bs;
            best_start_next = bst;
            best_end_next   = be;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg        <= '0;
            run_sum_reg    <= '0;
            run_start_reg  <= '0;
            best_sum_reg   <= '0;
            best_start_reg <= '0;
            best_end_reg   <= '0;
        end
        else if (s1_fire)
        begin
            idx_reg        <= idx_next;
            run_sum_reg    <= run_sum_next;
            run_start_reg  <= run_start_next;
            best_sum_reg   <= best_sum_next;
            best_start_reg <= best_start_next;
            best_end_reg   <= best_end_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/msc_result.sv @@
// Result register: saturates the best sum and forms the run center.
`default_nettype none

module msc_result import msc_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic res_valid,
    input  wire res_t res_data,
    output logic      res_space,
    msc_res_if.source res
);

    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [SUM_OUT_W-1:0] sum_reg;
    idx_t                 start_reg;
    idx_t                 end_reg;
    idx_t                 center_reg;

    logic [SUM_OUT_W-1:0] sum_sat;
    logic [IDX_W:0]       pos_sum;

    assign res_space = !out_valid_reg || res.ready;

    // Output formatting.
    always_comb
    begin
        if (res_data.best_sum > SUM_OUT_MAX)
            sum_sat = SUM_OUT_MAX[SUM_OUT_W-1:0];
        else
            sum_sat = res_data.best_sum[SUM_OUT_W-1:0];
        pos_sum = {1'b0, res_data.best_start} + {1'b0, res_data.best_end};
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_valid)
            out_valid_next = 1'b1;
        else if (res.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            sum_reg    <= sum_sat;
            start_reg  <= res_data.best_start;
            end_reg    <= res_data.best_end;
            center_reg <= pos_sum[IDX_W:1];
        end
    end

    assign res.valid      = out_valid_reg;
    assign res.best_sum   = sum_reg;
    assign res.best_start = start_reg;
    assign res.best_end   = end_reg;
    assign res.center     = center_reg;

endmodule

`default_nettype wire

@@ rtl/core/max_subarray_center_finder_core.sv @@
// A result is presented from the result register, which follows the input register that takes the line_end pixel.
// Throughput: one pixel per cycle unless a line_end pixel waits; the running-sum add and best compare sit
// between the input register and the line state registers.
// A line_end pixel waits in the input register only while a result is unread.
// Reset (rst_n low, asynchronous) empties both stages, sets the window to
// start 0 / end 127 and clears the line state.
`default_nettype none

module max_subarray_center_finder_core import msc_pkg::*;
#(
    parameter int LINE_PIXELS = 128
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    msc_pix_if.sink   pix,
    msc_res_if.source res,
    msc_cfg_if.sink   cfg
);

    win_t win;
    pix_t in_pix;
    logic res_valid;
    res_t res_data;
    logic res_space;

    assign in_pix = '{pixel_value: pix.pixel_value, line_end: pix.line_end};

    // Configuration registers.
    msc_cfg_regs u_cfg
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .win   (win)
    );

    // Running search over the line.
    msc_kadane #(
        .LINE_PIXELS (LINE_PIXELS)
    ) u_kadane
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .win       (win),
        .in_valid  (pix.valid),
        .in_ready  (pix.ready),
        .in_pix    (in_pix),
        .res_valid (res_valid),
        .res_data  (res_data),
        .res_space (res_space)
    );

    // Result register.
    msc_result u_result
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res_data  (res_data),
        .res_space (res_space),
        .res       (res)
    );

endmodule

`default_nettype wire

@@ rtl/core/msc_checker.sv @@
// Port-level checks of the maximum-subarray finder and their binding.
`default_nettype none

module msc_checker import msc_pkg::*;
(
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 pix_valid,
    input wire logic                 pix_ready,
    input wire logic                 pix_line_end,
    input wire logic                 res_valid,
    input wire logic                 res_ready,
    input wire logic [SUM_OUT_W-1:0] res_best_sum,
    input wire idx_t                 res_best_start,
    input wire idx_t                 res_best_end
);

    // A result held back keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_best_sum)
            && $stable(res_best_start) && $stable(res_best_end))
        else $error("result changed while stalled");

    // A new result follows an accepted line_end request.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(pix_valid && pix_ready && pix_line_end, 2))
        else $error("result without a line_end request");

    // A zero best sum means the empty run.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res_best_sum == '0) |-> res_best_start == res_best_end)
        else $error("zero sum with a non-empty run");

endmodule

bind max_subarray_center_finder_core msc_checker u_msc_checker
(
    .clk            (clk),
    .rst_n          (rst_n),
    .pix_valid      (pix.valid),
    .pix_ready      (pix.ready),
    .pix_line_end   (pix.line_end),
    .res_valid      (res.valid),
    .res_ready      (res.ready),
    .res_best_sum   (res.best_sum),
    .res_best_start (res.best_start),
    .res_best_end   (res.best_end)
);

`default_nettype wire
